// ===== sv/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// brs_pkg: shared types and constants of the bilinear RGB sampler
// Image geometry, field widths, pixel and result types, register indexes.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int FRAC_BITS  = 8;

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
  localparam int ADDR_BITS = ROW_BITS + COL_BITS;

  localparam int COORD_BITS     = 16;
  localparam int DIM_BITS       = 10;
  localparam int CHAN_BITS      = 8;
  localparam int PIXEL_BITS     = 3 * CHAN_BITS;
  localparam int CFG_INDEX_BITS = 4;

  // blend arithmetic widths
  localparam int WEIGHT_BITS = FRAC_BITS + 1;
  localparam int HSUM_BITS   = CHAN_BITS + FRAC_BITS;
  localparam int VSUM_BITS   = CHAN_BITS + 2 * FRAC_BITS;
  localparam int OUT_SHIFT   = 2 * FRAC_BITS;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(512);

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1);

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t rgb;
    logic   outside;
  } result_t;

endpackage

// ===== sv/brs_sample_if.sv =====
// ----------------------------------------------------------------------------
// brs_sample_if: input channel of the sampler
// Carries pixel write and sample transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface brs_sample_if import brs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [COORD_BITS-1:0] x_int;
  logic [COORD_BITS-1:0] y_int;
  logic [FRAC_BITS-1:0]  x_frac;
  logic [FRAC_BITS-1:0]  y_frac;
  logic [CHAN_BITS-1:0]  red_in;
  logic [CHAN_BITS-1:0]  green_in;
  logic [CHAN_BITS-1:0]  blue_in;

  modport source (
    output valid, kind, x_int, y_int, x_frac, y_frac, red_in, green_in, blue_in,
    input  ready
  );
  modport sink (
    input  valid, kind, x_int, y_int, x_frac, y_frac, red_in, green_in, blue_in,
    output ready
  );
endinterface

// ===== sv/brs_result_if.sv =====
// ----------------------------------------------------------------------------
// brs_result_if: result channel of the sampler
// Carries interpolated RGB values and the outside flag.
// ----------------------------------------------------------------------------
interface brs_result_if import brs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAN_BITS-1:0] red_out;
  logic [CHAN_BITS-1:0] green_out;
  logic [CHAN_BITS-1:0] blue_out;
  logic                 outside;

  modport source (
    output valid, red_out, green_out, blue_out, outside,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out, outside,
    output ready
  );
endinterface

// ===== sv/brs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// brs_cfg_if: configuration write channel
// Carries a register index and write data with valid/ready handshake.
// ----------------------------------------------------------------------------
interface brs_cfg_if import brs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [DIM_BITS-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/brs_pixel_ram.sv =====
// ----------------------------------------------------------------------------
// brs_pixel_ram: pixel store
// Port A writes or reads, port B reads; both read ports are registered.
// ----------------------------------------------------------------------------
module brs_pixel_ram #(
  parameter int ADDR_W = 18,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              we_a,
  input  logic [ADDR_W-1:0] addr_a,
  input  logic [DATA_W-1:0] wdata_a,
  input  logic [ADDR_W-1:0] addr_b,
  output logic [DATA_W-1:0] q_a,
  output logic [DATA_W-1:0] q_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem[addr_a] <= wdata_a;
    end else begin
      q_a <= mem[addr_a];
    end
  end

  always_ff @(posedge clk) begin
    q_b <= mem[addr_b];
  end

endmodule

// ===== sv/brs_blend.sv =====
// ----------------------------------------------------------------------------
// brs_blend: bilinear blend of a 2x2 neighbourhood
// Registered horizontal blends, then a vertical blend and shift toward the
// output register of the caller.
// ----------------------------------------------------------------------------
module brs_blend import brs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  pixel_t               p00,
  input  pixel_t               p01,
  input  pixel_t               p10,
  input  pixel_t               p11,
  input  logic [FRAC_BITS-1:0] fx,
  input  logic [FRAC_BITS-1:0] fy,
  output logic                 done,
  output pixel_t               rgb
);

  function automatic logic [HSUM_BITS-1:0] hmix(
    input logic [WEIGHT_BITS-1:0] w0,
    input logic [FRAC_BITS-1:0]   w1,
    input logic [CHAN_BITS-1:0]   a,
    input logic [CHAN_BITS-1:0]   b
  );
    return HSUM_BITS'(HSUM_BITS'(w0) * HSUM_BITS'(a) + HSUM_BITS'(w1) * HSUM_BITS'(b));
  endfunction

  function automatic logic [CHAN_BITS-1:0] vmix(
    input logic [WEIGHT_BITS-1:0] w0,
    input logic [FRAC_BITS-1:0]   w1,
    input logic [HSUM_BITS-1:0]   a,
    input logic [HSUM_BITS-1:0]   b
  );
    logic [VSUM_BITS-1:0] acc;
    acc = VSUM_BITS'(VSUM_BITS'(w0) * VSUM_BITS'(a) + VSUM_BITS'(w1) * VSUM_BITS'(b));
    return acc[OUT_SHIFT +: CHAN_BITS];
  endfunction

  logic [WEIGHT_BITS-1:0] wx;
  logic [WEIGHT_BITS-1:0] wy;
  logic [HSUM_BITS-1:0]   top_r, top_g, top_b;
  logic [HSUM_BITS-1:0]   bot_r, bot_g, bot_b;
  logic [FRAC_BITS-1:0]   fy_q;

  assign wx = WEIGHT_ONE - WEIGHT_BITS'(fx);
  assign wy = WEIGHT_ONE - WEIGHT_BITS'(fy_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      top_r <= hmix(wx, fx, p00.red,   p01.red);
      top_g <= hmix(wx, fx, p00.green, p01.green);
      top_b <= hmix(wx, fx, p00.blue,  p01.blue);
      bot_r <= hmix(wx, fx, p10.red,   p11.red);
      bot_g <= hmix(wx, fx, p10.green, p11.green);
      bot_b <= hmix(wx, fx, p10.blue,  p11.blue);
      fy_q  <= fy;
    end
  end

  always_comb begin
    rgb.red   = vmix(wy, fy_q, top_r, bot_r);
    rgb.green = vmix(wy, fy_q, top_g, bot_g);
    rgb.blue  = vmix(wy, fy_q, top_b, bot_b);
  end

endmodule

// ===== sv/bilinear_rgb_sampler.sv =====
// ----------------------------------------------------------------------------
// bilinear_rgb_sampler: RGB888 bilinear sampler over a pixel store
// Pixel write: taken in idle. Outside sample: result into the output register,
// or the hold stage on a stall. Inside sample: RD_TOP, RD_BOT, LAUNCH, WAIT;
// two neighbour pixels per cycle via both RAM read ports, then a two-step blend.
// Reset clears control state and sets both dimensions to 512; the pixel
// store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module bilinear_rgb_sampler import brs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  brs_sample_if.sink   sample,
  brs_result_if.source result,
  brs_cfg_if.sink      cfg
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RD_TOP = 5'b00010,
    S_RD_BOT = 5'b00100,
    S_LAUNCH = 5'b01000,
    S_WAIT   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [DIM_BITS-1:0] image_width, image_height;
  logic [DIM_BITS-1:0] w_eff, h_eff;

  logic [COL_BITS-1:0] col0, col1, col0_next, col1_next;
  logic [ROW_BITS-1:0] row0, row1, row0_next, row1_next;
  logic [FRAC_BITS-1:0] fx, fy;
  pixel_t top0, top1;

  logic                 accept, is_write, is_sample, in_image, write_ok;
  logic [COORD_BITS:0]  x_plus, y_plus;

  logic                 we_a;
  logic [ADDR_BITS-1:0] addr_a, addr_b;
  logic [PIXEL_BITS-1:0] q_a, q_b;

  logic    blend_done;
  pixel_t  blend_rgb;

  logic    push;
  result_t push_data;
  logic    out_valid, hold_valid;
  result_t out_data, hold_data;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        REG_IMAGE_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  assign w_eff = ({6'b0, image_width} > COORD_BITS'(MAX_WIDTH)) ?
                 DIM_BITS'(MAX_WIDTH) : image_width;
  assign h_eff = ({6'b0, image_height} > COORD_BITS'(MAX_HEIGHT)) ?
                 DIM_BITS'(MAX_HEIGHT) : image_height;

  // input decode
  assign sample.ready = (state == S_IDLE) && !hold_valid;
  assign accept    = sample.valid && sample.ready;
  assign is_write  = accept && (sample.kind == KIND_WRITE);
  assign is_sample = accept && (sample.kind == KIND_SAMPLE);

  assign in_image = (sample.x_int < COORD_BITS'(w_eff)) &&
                    (sample.y_int < COORD_BITS'(h_eff));
  assign write_ok = (sample.x_int < COORD_BITS'(MAX_WIDTH)) &&
                    (sample.y_int < COORD_BITS'(MAX_HEIGHT));

  assign x_plus = {1'b0, sample.x_int} + (COORD_BITS+1)'(1);
  assign y_plus = {1'b0, sample.y_int} + (COORD_BITS+1)'(1);

  // clamp the far neighbours to the last column and row in use
  always_comb begin
    col0_next = sample.x_int[COL_BITS-1:0];
    row0_next = sample.y_int[ROW_BITS-1:0];
    col1_next = (x_plus < (COORD_BITS+1)'(w_eff)) ? x_plus[COL_BITS-1:0] : col0_next;
    row1_next = (y_plus < (COORD_BITS+1)'(h_eff)) ? y_plus[ROW_BITS-1:0] : row0_next;
  end

  always_ff @(posedge clk) begin
    if (is_sample) begin
      col0 <= col0_next;
      col1 <= col1_next;
      row0 <= row0_next;
      row1 <= row1_next;
      fx   <= sample.x_frac;
      fy   <= sample.y_frac;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (is_sample && in_image) state_next = S_RD_TOP;
      S_RD_TOP: state_next = S_RD_BOT;
      S_RD_BOT: state_next = S_LAUNCH;
      S_LAUNCH: state_next = S_WAIT;
      S_WAIT:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memory ports
  always_comb begin
    we_a   = is_write && write_ok;
    addr_a = {sample.y_int[ROW_BITS-1:0], sample.x_int[COL_BITS-1:0]};
    addr_b = {row0, col1};
    case (state)
      S_RD_TOP: begin
        addr_a = {row0, col0};
        addr_b = {row0, col1};
      end
      S_RD_BOT: begin
        addr_a = {row1, col0};
        addr_b = {row1, col1};
      end
      default: ;
    endcase
  end

  brs_pixel_ram #(
    .ADDR_W (ADDR_BITS),
    .DATA_W (PIXEL_BITS)
  ) u_ram (
    .clk     (clk),
    .we_a    (we_a),
    .addr_a  (addr_a),
    .wdata_a ({sample.red_in, sample.green_in, sample.blue_in}),
    .addr_b  (addr_b),
    .q_a     (q_a),
    .q_b     (q_b)
  );

  // hold the top row while the bottom row comes out of the memory
  always_ff @(posedge clk) begin
    if (state == S_RD_BOT) begin
      top0 <= pixel_t'(q_a);
      top1 <= pixel_t'(q_b);
    end
  end

  brs_blend u_blend (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_LAUNCH),
    .p00   (top0),
    .p01   (top1),
    .p10   (pixel_t'(q_a)),
    .p11   (pixel_t'(q_b)),
    .fx    (fx),
    .fy    (fy),
    .done  (blend_done),
    .rgb   (blend_rgb)
  );

  // result output register with a hold stage behind it
  always_comb begin
    push = blend_done || (is_sample && !in_image);
    if (blend_done) begin
      push_data.rgb     = blend_rgb;
      push_data.outside = 1'b0;
    end else begin
      push_data.rgb     = '0;
      push_data.outside = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= hold_valid;
      end
      if (push && out_valid && !result.ready) begin
        hold_valid <= 1'b1;
      end else if (result.ready) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && (!out_valid || result.ready)) begin
      out_data <= push_data;
    end else if (out_valid && result.ready && hold_valid) begin
      out_data <= hold_data;
    end
    if (push && out_valid && !result.ready) begin
      hold_data <= push_data;
    end
  end

  assign result.valid     = out_valid;
  assign result.red_out   = out_data.rgb.red;
  assign result.green_out = out_data.rgb.green;
  assign result.blue_out  = out_data.rgb.blue;
  assign result.outside   = out_data.outside;

endmodule

// ===== test/brs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_checker: scoreboard for the bilinear RGB sampler
// Mirrors pixel writes and register writes seen on the channels, predicts
// the result of every accepted sample and compares it field by field with
// the result channel. Reports the mismatch count and the open samples.
// ----------------------------------------------------------------------------
module brs_checker import brs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  brs_sample_if sample,
  brs_result_if result,
  brs_cfg_if    cfg,
  output int    mismatches,
  output int    outstanding
);

  pixel_t              image_mem [MAX_WIDTH*MAX_HEIGHT];
  logic [DIM_BITS-1:0] width_reg;
  logic [DIM_BITS-1:0] height_reg;
  result_t             sample_results_q [$];
  int                  error_total = 0;

  function automatic logic [CHAN_BITS-1:0] mix_channel(
    input logic [CHAN_BITS-1:0] p00, p01, p10, p11,
    input logic [FRAC_BITS-1:0] fx, fy);
    int unsigned one;
    int unsigned upper;
    int unsigned lower;
    one   = 32'(WEIGHT_ONE);
    upper = (one - 32'(fx)) * 32'(p00) + 32'(fx) * 32'(p01);
    lower = (one - 32'(fx)) * 32'(p10) + 32'(fx) * 32'(p11);
    return CHAN_BITS'(((one - 32'(fy)) * upper + 32'(fy) * lower) >> OUT_SHIFT);
  endfunction

  function automatic result_t predict_sample(
    input logic [COORD_BITS-1:0] xi, yi, input logic [FRAC_BITS-1:0] fx, fy);
    int unsigned w;
    int unsigned h;
    int unsigned x1;
    int unsigned y1;
    pixel_t      p00, p01, p10, p11;
    result_t     r;
    // oversized dimensions act as the store size
    w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    r = '0;
    if (xi >= w || yi >= h) begin
      r.outside = 1'b1;
      return r;
    end
    // clamp the far neighbours to the last column and row
    x1  = (xi + 1 < w) ? xi + 1 : xi;
    y1  = (yi + 1 < h) ? yi + 1 : yi;
    p00 = image_mem[yi * MAX_WIDTH + xi];
    p01 = image_mem[yi * MAX_WIDTH + x1];
    p10 = image_mem[y1 * MAX_WIDTH + xi];
    p11 = image_mem[y1 * MAX_WIDTH + x1];
    r.rgb.red   = mix_channel(p00.red, p01.red, p10.red, p11.red, fx, fy);
    r.rgb.green = mix_channel(p00.green, p01.green, p10.green, p11.green, fx, fy);
    r.rgb.blue  = mix_channel(p00.blue, p01.blue, p10.blue, p11.blue, fx, fy);
    return r;
  endfunction

  function automatic int field_check(input string field,
                                     input logic [CHAN_BITS-1:0] want, got);
    if (got === want) return 0;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      sample_results_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        got.rgb.red   = result.red_out;
        got.rgb.green = result.green_out;
        got.rgb.blue  = result.blue_out;
        got.outside   = result.outside;
        if (sample_results_q.size() == 0) begin
          $display("%0t: result transaction with no sample open: r=%0d g=%0d b=%0d outside=%0d",
                   $time, got.rgb.red, got.rgb.green, got.rgb.blue, got.outside);
          error_total++;
        end else begin
          want = sample_results_q.pop_front();
          error_total += field_check("red_out", want.rgb.red, got.rgb.red);
          error_total += field_check("green_out", want.rgb.green, got.rgb.green);
          error_total += field_check("blue_out", want.rgb.blue, got.rgb.blue);
          error_total += field_check("outside", CHAN_BITS'(want.outside),
                                     CHAN_BITS'(got.outside));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_IMAGE_WIDTH:  width_reg = cfg.data;
          REG_IMAGE_HEIGHT: height_reg = cfg.data;
          default: ;
        endcase
      end
      if (sample.valid && sample.ready) begin
        if (sample.kind == KIND_WRITE) begin
          // drop writes beyond the store
          if (sample.x_int < MAX_WIDTH && sample.y_int < MAX_HEIGHT)
            image_mem[sample.y_int * MAX_WIDTH + sample.x_int] =
              {sample.red_in, sample.green_in, sample.blue_in};
        end else begin
          sample_results_q.push_back(predict_sample(sample.x_int, sample.y_int,
                                                    sample.x_frac, sample.y_frac));
        end
      end
    end
    outstanding <= sample_results_q.size();
    mismatches  <= error_total;
  end

endmodule

// ===== test/tb_bilinear_rgb_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilinear_rgb_sampler: testbench of the bilinear RGB sampler
// Drives pixel writes, samples and register writes with random idling on
// both sides; every sample only reads pixels written before. A checker
// beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_bilinear_rgb_sampler;
  import brs_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 12;
  localparam int PHASES          = 10;
  localparam int PHASE_ITEMS     = 20;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = '1;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   send_idle_pct  = 0;
  int   stall_pct      = 0;
  int   hold_off_reqs  = 0;
  int   hold_offs_done = 0;
  int   eff_width      = MAX_WIDTH;
  int   eff_height     = MAX_HEIGHT;
  bit   painted [int];
  int   phase_width  [PHASES] = '{8, 1, 512, 3, 1023, 16, 0, 2, 40, 512};
  int   phase_height [PHASES] = '{8, 1, 512, 16, 700, 5, 9, 2, 1, 512};

  brs_sample_if smp ();
  brs_result_if res ();
  brs_cfg_if    cfg ();

  bilinear_rgb_sampler dut (
    .clk, .rst, .sample(smp), .result(res), .cfg(cfg)
  );

  brs_checker chk (
    .clk, .rst, .sample(smp), .result(res), .cfg(cfg), .mismatches, .outstanding
  );

  always #5 clk = ~clk;

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_reqs != hold_offs_done) begin
        hold_offs_done++;
        res.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        res.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic pixel_t rand_pixel();
    logic [PIXEL_BITS-1:0] v;
    v = PIXEL_BITS'($urandom);
    return v;
  endfunction

  function automatic int pick_frac();
    case ($urandom_range(5))
      0:       return 0;
      1:       return (1 << FRAC_BITS) - 1;
      default: return $urandom_range((1 << FRAC_BITS) - 1);
    endcase
  endfunction

  task automatic push_item(input logic kind, input int x, y, fx, fy, input pixel_t px);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid    <= 1'b1;
    smp.kind     <= kind;
    smp.x_int    <= COORD_BITS'(x);
    smp.y_int    <= COORD_BITS'(y);
    smp.x_frac   <= FRAC_BITS'(fx);
    smp.y_frac   <= FRAC_BITS'(fy);
    smp.red_in   <= px.red;
    smp.green_in <= px.green;
    smp.blue_in  <= px.blue;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    if (kind == KIND_WRITE && x < MAX_WIDTH && y < MAX_HEIGHT)
      painted[y * MAX_WIDTH + x] = 1'b1;
  endtask

  task automatic paint(input int x, y);
    push_item(KIND_WRITE, x, y, pick_frac(), pick_frac(), rand_pixel());
  endtask

  task automatic cover_pixel(input int x, y);
    if (!painted.exists(y * MAX_WIDTH + x)) paint(x, y);
  endtask

  // write any missing neighbour first, so no sample reads an empty entry
  task automatic sample_at(input int x, y, fx, fy);
    int x1;
    int y1;
    if (x < eff_width && y < eff_height) begin
      x1 = (x + 1 < eff_width) ? x + 1 : x;
      y1 = (y + 1 < eff_height) ? y + 1 : y;
      cover_pixel(x, y);
      cover_pixel(x1, y);
      cover_pixel(x, y1);
      cover_pixel(x1, y1);
    end
    push_item(KIND_SAMPLE, x, y, fx, fy, rand_pixel());
  endtask

  task automatic random_sample();
    int x;
    int y;
    int sel;
    sel = $urandom_range(99);
    if (sel < 75 && eff_width > 0 && eff_height > 0) begin
      x = ($urandom_range(3) == 0) ? eff_width - 1 : $urandom_range(eff_width - 1);
      y = ($urandom_range(3) == 0) ? eff_height - 1 : $urandom_range(eff_height - 1);
    end else if (sel < 88) begin
      // just past the right or bottom edge
      if ($urandom_range(1)) begin
        x = eff_width;
        y = $urandom_range(65535);
      end else begin
        x = $urandom_range(65535);
        y = eff_height;
      end
    end else begin
      x = $urandom_range(65535);
      y = $urandom_range(65535);
      if (x < eff_width && y < eff_height) x = $urandom_range(65535, eff_width);
    end
    sample_at(x, y, pick_frac(), pick_frac());
  endtask

  task automatic random_write();
    int sel;
    sel = $urandom_range(9);
    if (sel < 2)
      paint($urandom_range(65535), $urandom_range(65535));
    else if (sel < 6 && eff_width > 0 && eff_height > 0)
      paint($urandom_range(eff_width - 1), $urandom_range(eff_height - 1));
    else
      paint($urandom_range(MAX_WIDTH - 1), $urandom_range(MAX_HEIGHT - 1));
  endtask

  // hold the sender until every open sample has returned
  task automatic drain();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_BITS-1:0] index, input int value);
    drain();
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= DIM_BITS'(value);
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (index == REG_IMAGE_WIDTH)
      eff_width = (value > MAX_WIDTH) ? MAX_WIDTH : value;
    else if (index == REG_IMAGE_HEIGHT)
      eff_height = (value > MAX_HEIGHT) ? MAX_HEIGHT : value;
  endtask

  initial begin
    int last_x;
    int last_y;

    rst          <= 1'b1;
    smp.valid    <= 1'b0;
    smp.kind     <= KIND_WRITE;
    smp.x_int    <= '0;
    smp.y_int    <= '0;
    smp.x_frac   <= '0;
    smp.y_frac   <= '0;
    smp.red_in   <= '0;
    smp.green_in <= '0;
    smp.blue_in  <= '0;
    cfg.valid    <= 1'b0;
    cfg.index    <= REG_IMAGE_WIDTH;
    cfg.data     <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: corners, clamping, ignored writes and register extremes
    last_x = MAX_WIDTH - 1;
    last_y = MAX_HEIGHT - 1;
    push_item(KIND_WRITE, 0, 0, 0, 0, 24'h000000);
    push_item(KIND_WRITE, last_x, last_y, 8'hFF, 8'hFF, 24'hFFFFFF);
    push_item(KIND_WRITE, last_x - 1, last_y - 1, 0, 0, 24'hFF0000);
    push_item(KIND_WRITE, last_x, last_y - 1, 0, 0, 24'h00FF00);
    push_item(KIND_WRITE, last_x - 1, last_y, 0, 0, 24'h0000FF);
    sample_at(last_x, last_y, 255, 255);
    sample_at(last_x - 1, last_y - 1, 0, 0);
    sample_at(last_x - 1, last_y - 1, 255, 255);
    sample_at(last_x - 1, last_y - 1, 128, 64);
    sample_at(last_x - 1, last_y, 200, 100);
    sample_at(0, 0, 255, 0);
    sample_at(MAX_WIDTH, 0, 17, 33);
    sample_at(0, MAX_HEIGHT, 0, 255);
    sample_at(65535, 65535, 255, 255);
    push_item(KIND_WRITE, MAX_WIDTH, 0, 0, 0, 24'hFFFFFF);
    push_item(KIND_WRITE, 0, MAX_HEIGHT, 0, 0, 24'hFFFFFF);
    push_item(KIND_WRITE, 65535, 65535, 0, 0, 24'hFFFFFF);
    sample_at(last_x - 1, last_y - 1, 255, 255);
    set_reg(REG_IMAGE_WIDTH, 1);
    set_reg(REG_IMAGE_HEIGHT, 1);
    sample_at(0, 0, 255, 255);
    sample_at(1, 0, 0, 0);
    sample_at(0, 1, 0, 0);
    set_reg(REG_UNUSED, 5);
    sample_at(0, 0, 99, 1);
    set_reg(REG_IMAGE_WIDTH, 0);
    sample_at(0, 0, 0, 0);
    set_reg(REG_IMAGE_WIDTH, 1023);
    set_reg(REG_IMAGE_HEIGHT, 1023);
    sample_at(last_x, last_y, 1, 254);

    // fill the block while results are held off, then pause until drained
    set_reg(REG_IMAGE_WIDTH, 4);
    set_reg(REG_IMAGE_HEIGHT, 4);
    hold_off_reqs++;
    repeat (40) random_sample();
    drain();

    for (int p = 0; p < PHASES; p++) begin
      set_reg(REG_IMAGE_WIDTH, phase_width[p]);
      set_reg(REG_IMAGE_HEIGHT, phase_height[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 55; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 55; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 70) random_sample();
        else random_write();
        if ($urandom_range(39) == 0) drain();
      end
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
